@@ hw/rtl/linear_probe_hash_table_assert.svh @@
// Assertion macros for the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define LPHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpht assertion failed");

// Implication shorthand built on the macro above.
`define LPHT_ASSERT_IMP(lbl, pre, post) \
  `LPHT_ASSERT(lbl, (pre) |-> (post))

`endif

@@ hw/rtl/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

  localparam int SLOT_COUNT  = 26;
  localparam int MAX_LETTERS = 10;
  localparam int LETTER_W    = 5;
  localparam int KEY_W       = LETTER_W * MAX_LETTERS;
  localparam int LEN_W       = 4;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;
  localparam op_t OP_LIST   = 2'd3;

  localparam status_t RES_OK    = 3'd0;
  localparam status_t RES_DUP   = 3'd1;
  localparam status_t RES_FULL  = 3'd2;
  localparam status_t RES_MISS  = 3'd3;
  localparam status_t RES_ENTRY = 3'd4;
  localparam status_t RES_EMPTY = 3'd5;

  typedef enum logic [1:0] {
    ST_NEVER = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  typedef struct packed {
    slot_st_e st;
    key_t     key;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpht_if.sv @@
`default_nettype none

interface lpht_in_if;
  logic                 valid;
  logic                 ready;
  lpht_pkg::op_t        operation;
  lpht_pkg::key_t       key_letters;
  lpht_pkg::len_t       key_length;

  modport source (output valid, output operation, output key_letters, output key_length,
                  input ready);
  modport sink (input valid, input operation, input key_letters, input key_length,
                output ready);
endinterface

interface lpht_out_if;
  logic                 valid;
  logic                 ready;
  lpht_pkg::status_t    status;
  lpht_pkg::slot_t      slot_index;
  lpht_pkg::key_t       key_out;
  logic                 last;

  modport source (output valid, output status, output slot_index, output key_out,
                  output last, input ready);
  modport sink (input valid, input status, input slot_index, input key_out, input last,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
// Linear probing hash table, 26 slots, lower-case keys packed 5 bits per letter.
// in_i  : one beat per command (insert, remove, lookup, list) with key and length.
// out_o : result beats; insert/remove/lookup give one beat, list gives one beat
//         per live slot in slot order (or one list-empty beat); last marks the
//         final beat of a command.
// One command is worked at a time; in_i.ready is high only while idle.
// Slot state and keys sit in one synchronous RAM, read one slot per cycle.
// Insert/remove/lookup: probe from the home slot for up to 26 slots, then
// issue the result (S_DONE). Insert and remove write back when it is issued.
// List: scans all 26 slots in slot order, then S_LEND gives the final beat.
// A result beat sits in an output register; the next command is accepted
// while it waits. A stalled receiver holds a list scan at the next live slot.
// Reset: all slots read as never used (per-slot valid flags cleared at once),
// no clearing pass; in_i.ready is high from reset on (state resets to idle).
`default_nettype none

module linear_probe_hash_table (
  input  logic clk_i,
  input  logic rst_ni,
  lpht_in_if.sink    in_i,
  lpht_out_if.source out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_DONE  = 3'd2;
  localparam logic [2:0] S_LIST  = 3'd3;
  localparam logic [2:0] S_LEND  = 3'd4;

  localparam lpht_pkg::slot_t LAST_SLOT = lpht_pkg::SLOT_W'(lpht_pkg::SLOT_COUNT - 1);

  lpht_pkg::entry_t mem_q [lpht_pkg::SLOT_COUNT];
  lpht_pkg::entry_t rdata_q;

  logic [2:0]                      state_q, state_d;
  logic [lpht_pkg::SLOT_COUNT-1:0] vld_q;
  lpht_pkg::slot_t                 rd_addr_q, rd_addr_d;
  lpht_pkg::op_t                   op_q, op_d;
  lpht_pkg::key_t                  key_q, key_d;
  lpht_pkg::slot_t                 cnt_q, cnt_d;
  lpht_pkg::slot_t                 ff_q, ff_d;
  logic                            ff_vld_q, ff_vld_d;
  lpht_pkg::status_t               res_status_q, res_status_d;
  lpht_pkg::slot_t                 res_slot_q, res_slot_d;
  logic                            we_q, we_d;
  lpht_pkg::slot_st_e              wst_q, wst_d;
  logic                            pend_vld_q, pend_vld_d;
  lpht_pkg::slot_t                 pend_slot_q, pend_slot_d;
  lpht_pkg::key_t                  pend_key_q, pend_key_d;

  logic                            out_valid_q, out_valid_d;
  lpht_pkg::status_t               out_status_q, out_status_d;
  lpht_pkg::slot_t                 out_slot_q, out_slot_d;
  lpht_pkg::key_t                  out_key_q, out_key_d;
  logic                            out_last_q, out_last_d;

  lpht_pkg::len_t                  len_c;
  lpht_pkg::key_t                  key_c;
  logic [lpht_pkg::LETTER_W-1:0]   ll_c;
  lpht_pkg::slot_t                 home_c;
  lpht_pkg::slot_st_e              cur_st;
  lpht_pkg::slot_t                 nxt_addr;
  logic                            cur_live, cur_never, cur_hit, ff_any;
  lpht_pkg::slot_t                 ff_pos;
  logic                            out_free, accept, mem_we;

  // key decode: clamp length, mask unused letters, home from last letter
  always_comb begin
    len_c = in_i.key_length;
    if (len_c == '0) begin
      len_c = lpht_pkg::LEN_W'(1);
    end else if (len_c > lpht_pkg::LEN_W'(lpht_pkg::MAX_LETTERS)) begin
      len_c = lpht_pkg::LEN_W'(lpht_pkg::MAX_LETTERS);
    end
    key_c = '0;
    ll_c  = '0;
    for (int i = 0; i < lpht_pkg::MAX_LETTERS; i++) begin
      if (lpht_pkg::LEN_W'(i) < len_c) begin
        key_c[i*lpht_pkg::LETTER_W +: lpht_pkg::LETTER_W] =
          in_i.key_letters[i*lpht_pkg::LETTER_W +: lpht_pkg::LETTER_W];
      end
      if (lpht_pkg::LEN_W'(i + 1) == len_c) begin
        ll_c = in_i.key_letters[i*lpht_pkg::LETTER_W +: lpht_pkg::LETTER_W];
      end
    end
    if (ll_c == '0) begin
      home_c = LAST_SLOT;
    end else if (ll_c > lpht_pkg::LETTER_W'(lpht_pkg::SLOT_COUNT)) begin
      home_c = lpht_pkg::SLOT_W'(ll_c - lpht_pkg::LETTER_W'(lpht_pkg::SLOT_COUNT + 1));
    end else begin
      home_c = lpht_pkg::SLOT_W'(ll_c - lpht_pkg::LETTER_W'(1));
    end
  end

  assign cur_st    = vld_q[rd_addr_q] ? rdata_q.st : lpht_pkg::ST_NEVER;
  assign cur_live  = (cur_st == lpht_pkg::ST_LIVE);
  assign cur_never = (cur_st == lpht_pkg::ST_NEVER);
  assign cur_hit   = cur_live && (rdata_q.key == key_q);
  assign ff_any    = ff_vld_q || !cur_live;
  assign ff_pos    = ff_vld_q ? ff_q : rd_addr_q;
  assign nxt_addr  = (rd_addr_q == LAST_SLOT) ? '0 : rd_addr_q + lpht_pkg::SLOT_W'(1);
  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && (state_q == S_IDLE);
  assign mem_we    = (state_q == S_DONE) && out_free && we_q;

  always_comb begin
    state_d      = state_q;
    rd_addr_d    = rd_addr_q;
    op_d         = op_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    ff_d         = ff_q;
    ff_vld_d     = ff_vld_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    we_d         = we_q;
    wst_d        = wst_q;
    pend_vld_d   = pend_vld_q;
    pend_slot_d  = pend_slot_q;
    pend_key_d   = pend_key_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_key_d    = out_key_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = in_i.operation;
          key_d      = key_c;
          cnt_d      = '0;
          ff_vld_d   = 1'b0;
          pend_vld_d = 1'b0;
          if (in_i.operation == lpht_pkg::OP_LIST) begin
            rd_addr_d = '0;
            state_d   = S_LIST;
          end else begin
            rd_addr_d = home_c;
            state_d   = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        rd_addr_d = nxt_addr;
        cnt_d     = cnt_q + lpht_pkg::SLOT_W'(1);
        if ((cur_st == lpht_pkg::ST_TOMB) && !ff_vld_q) begin
          ff_d     = rd_addr_q;
          ff_vld_d = 1'b1;
        end
        if (cur_hit || cur_never || (cnt_q == LAST_SLOT)) begin
          state_d      = S_DONE;
          we_d         = 1'b0;
          wst_d        = lpht_pkg::ST_LIVE;
          res_slot_d   = '0;
          res_status_d = lpht_pkg::RES_MISS;
          case (op_q)
            lpht_pkg::OP_INSERT: begin
              if (cur_hit) begin
                res_status_d = lpht_pkg::RES_DUP;
                res_slot_d   = rd_addr_q;
              end else if (ff_any) begin
                res_status_d = lpht_pkg::RES_OK;
                res_slot_d   = ff_pos;
                we_d         = 1'b1;
              end else begin
                res_status_d = lpht_pkg::RES_FULL;
              end
            end
            lpht_pkg::OP_REMOVE: begin
              if (cur_hit) begin
                res_status_d = lpht_pkg::RES_OK;
                res_slot_d   = rd_addr_q;
                we_d         = 1'b1;
                wst_d        = lpht_pkg::ST_TOMB;
              end
            end
            default: begin
              if (cur_hit) begin
                res_status_d = lpht_pkg::RES_OK;
                res_slot_d   = rd_addr_q;
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_key_d    = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_LIST: begin
        if (cur_live && pend_vld_q && !out_free) begin
          rd_addr_d = rd_addr_q;
        end else begin
          if (cur_live) begin
            if (pend_vld_q) begin
              out_valid_d  = 1'b1;
              out_status_d = lpht_pkg::RES_ENTRY;
              out_slot_d   = pend_slot_q;
              out_key_d    = pend_key_q;
              out_last_d   = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = rd_addr_q;
            pend_key_d  = rdata_q.key;
          end
          rd_addr_d = nxt_addr;
          if (rd_addr_q == LAST_SLOT) begin
            state_d = S_LEND;
          end
        end
      end
      S_LEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_vld_q) begin
            out_status_d = lpht_pkg::RES_ENTRY;
            out_slot_d   = pend_slot_q;
            out_key_d    = pend_key_q;
          end else begin
            out_status_d = lpht_pkg::RES_EMPTY;
            out_slot_d   = '0;
            out_key_d    = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[res_slot_q] <= '{st: wst_q, key: key_q};
    end
    rdata_q <= mem_q[rd_addr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      ff_vld_q    <= 1'b0;
      we_q        <= 1'b0;
      rd_addr_q   <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_vld_q  <= pend_vld_d;
      ff_vld_q    <= ff_vld_d;
      we_q        <= we_d;
      rd_addr_q   <= rd_addr_d;
      cnt_q       <= cnt_d;
      if (mem_we) begin
        vld_q[res_slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    ff_q         <= ff_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    wst_q        <= wst_d;
    pend_slot_q  <= pend_slot_d;
    pend_key_q   <= pend_key_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_key_q    <= out_key_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.key_out    = out_key_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/lpht_checker.sv @@
`default_nettype none

`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lpht_pkg::status_t   status_i,
  input lpht_pkg::slot_t     slot_index_i,
  input lpht_pkg::key_t      key_out_i,
  input logic                last_i
);

  // stalled result beat holds
  `LPHT_ASSERT_IMP(a_out_hold, out_valid_i && !out_ready_i, ##1 (out_valid_i && $stable(status_i) && $stable(slot_index_i) && $stable(key_out_i) && $stable(last_i)))

  // one command at a time
  `LPHT_ASSERT_IMP(a_busy_after_accept, in_valid_i && in_ready_i, ##1 !in_ready_i)

  `LPHT_ASSERT_IMP(a_slot_range, out_valid_i, slot_index_i < lpht_pkg::SLOT_W'(lpht_pkg::SLOT_COUNT))

  // only list entries carry a key and may be non-final
  `LPHT_ASSERT_IMP(a_key_zero, out_valid_i && (status_i != lpht_pkg::RES_ENTRY), key_out_i == '0)

  `LPHT_ASSERT_IMP(a_single_last, out_valid_i && (status_i != lpht_pkg::RES_ENTRY), last_i)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .slot_index_i (out_o.slot_index),
  .key_out_i    (out_o.key_out),
  .last_i       (out_o.last)
);

`default_nettype wire
